// ----- rtl/tsts_pkg.sv -----
// shared types and constants of the sample tank sequencer
package tsts_pkg;

    // field and counter widths
    localparam int TIME_W     = 20;
    localparam int CNT_W      = 8;
    localparam int PERIOD_W   = 16;
    localparam int PH_W       = 14;
    localparam int TDS_W      = 16;
    localparam int TEMP_W     = 15;
    localparam int PH_SUM_W   = 22;
    localparam int TDS_SUM_W  = 24;
    localparam int TEMP_SUM_W = 23;
    localparam int DIV_W      = 24;
    localparam int DIV_CNT_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // register values after reset
    localparam logic [TIME_W-1:0]   FILL_TIME_RST     = 20'd5000;
    localparam logic [TIME_W-1:0]   SETTLE_TIME_RST   = 20'd10000;
    localparam logic [TIME_W-1:0]   DRAIN_TIME_RST    = 20'd5000;
    localparam logic [CNT_W-1:0]    SAMPLES_TOTAL_RST = 8'd30;
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd100;
    localparam logic [CNT_W-1:0]    WARMUP_DROP_RST   = 8'd10;

    localparam logic [TIME_W-1:0] ELAPSED_MAX = '1;

    // request opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_TIME     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_TIME    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_TOTAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_DROP   = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_FILL   = 3'd1,
        PH_SETTLE = 3'd2,
        PH_READ   = 3'd3,
        PH_DRAIN  = 3'd4
    } t_phase;

    typedef enum logic {
        CS_IDLE,
        CS_DIV
    } t_ctl_state;

    typedef enum logic [1:0] {
        DV_PH,
        DV_TDS,
        DV_TEMP
    } t_div_sel;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- rtl/tsts_item_if.sv -----
// input request channel
interface tsts_item_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [tsts_pkg::PH_W-1:0]     ph_value;
    logic [tsts_pkg::TDS_W-1:0]    tds_value;
    logic signed [tsts_pkg::TEMP_W-1:0] temp_value;

    modport source (output valid, opcode, ph_value, tds_value, temp_value, input ready);
    modport sink   (input valid, opcode, ph_value, tds_value, temp_value, output ready);
endinterface

// ----- rtl/tsts_result_if.sv -----
// result channel
interface tsts_result_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    phase;
    logic                          pump_on;
    logic                          valve_open;
    logic                          sample_taken;
    logic                          average_ready;
    logic [tsts_pkg::PH_W-1:0]     avg_ph;
    logic [tsts_pkg::TDS_W-1:0]    avg_tds;
    logic signed [tsts_pkg::TEMP_W-1:0] avg_temp;

    modport source (output valid, phase, pump_on, valve_open, sample_taken, average_ready,
                    avg_ph, avg_tds, avg_temp, input ready);
    modport sink   (input valid, phase, pump_on, valve_open, sample_taken, average_ready,
                    avg_ph, avg_tds, avg_temp, output ready);
endinterface

// ----- rtl/tsts_cfg_if.sv -----
// configuration write channel
interface tsts_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [tsts_pkg::CFG_IDX_W-1:0]     index;
    logic [tsts_pkg::CFG_DATA_W-1:0]    wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink   (input valid, index, wdata, output ready);
endinterface

// ----- rtl/tsts_divider.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module tsts_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tsts_pkg::DIV_W-1:0]    i_dividend,
    input  logic [tsts_pkg::CNT_W-1:0]    i_divisor,
    output tsts_pkg::t_div_stat           o_stat,
    output logic [tsts_pkg::DIV_W-1:0]    o_quotient
);
    import tsts_pkg::*;

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_dvd;
    logic [CNT_W-1:0]     r_rem;

    logic [CNT_W:0]       rem_sh;
    logic [CNT_W+1:0]     diff;
    logic                 fits;
    logic [CNT_W-1:0]     n_rem;
    logic                 last;

    // one shift-subtract step
    always_comb begin
        rem_sh = {r_rem, r_dvd[DIV_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, i_divisor};
        fits   = ~diff[CNT_W+1];
        n_rem  = fits ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        last   = (r_cnt == DIV_CNT_W'(DIV_W - 1));
    end

    assign o_quotient  = {r_dvd[DIV_W-2:0], fits};
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy & last;

    // dividend register shifts quotient bits in from the bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_dvd  <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_dvd <= o_quotient;
            r_rem <= n_rem;
            r_cnt <= r_cnt + 1'b1;
            if (last) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// ----- rtl/timed_sampling_tank_sequencer_unit.sv -----
// sample tank sequencer: fill, settle, read with averaging, drain
// results: registered, each in the cycle after its request, but for the request ending the read
// phase with kept samples; that one waits on the shared one-bit-per-cycle divider, which works
// out the three averages in turn
// throughput: one request per cycle otherwise, with results taken; not ready while averaging
// reset: synchronous, returns registers to their defaults, phase idle, averages zero
module timed_sampling_tank_sequencer_unit #(
    parameter int MAX_SAMPLES = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tsts_item_if.sink     i_item,
    tsts_result_if.source o_result,
    tsts_cfg_if.sink      i_cfg
);
    import tsts_pkg::*;

    localparam logic [9:0] MAX_LIM = 10'(MAX_SAMPLES);

    // configuration registers
    logic [TIME_W-1:0]   r_fill_time;
    logic [TIME_W-1:0]   r_settle_time;
    logic [TIME_W-1:0]   r_drain_time;
    logic [CNT_W-1:0]    r_samples_total;
    logic [PERIOD_W-1:0] r_sample_period;
    logic [CNT_W-1:0]    r_warmup_drop;

    // sequencer state
    t_phase                  r_phase,     n_phase;
    logic [TIME_W-1:0]       r_elapsed,   n_elapsed;
    logic [CNT_W-1:0]        r_index,     n_index;
    logic [CNT_W-1:0]        r_kept,      n_kept;
    logic [PH_SUM_W-1:0]     r_ph_sum,    n_ph_sum;
    logic [TDS_SUM_W-1:0]    r_tds_sum,   n_tds_sum;
    logic signed [TEMP_SUM_W-1:0] r_temp_sum, n_temp_sum;
    logic [PH_W-1:0]         r_mean_ph,   n_mean_ph;
    logic [TDS_W-1:0]        r_mean_tds,  n_mean_tds;
    logic signed [TEMP_W-1:0] r_mean_temp, n_mean_temp;

    // control and result flags
    t_ctl_state r_ctl,       n_ctl;
    t_div_sel   r_sel,       n_sel;
    logic       r_out_valid, n_out_valid;
    logic       r_taken,     n_taken;
    logic       r_avg_rdy,   n_avg_rdy;

    logic                  accept;
    logic [TIME_W-1:0]     elapsed_inc;
    logic [CNT_W-1:0]      total;
    logic                  keep;
    logic                  temp_neg;
    logic [TEMP_SUM_W-1:0] temp_mag;
    logic [CNT_W-1:0]      half_k;
    logic [DIV_W-1:0]      dividend;
    logic                  div_start;
    t_div_stat             div_stat;
    logic [DIV_W-1:0]      quotient;

    // handshakes
    assign i_item.ready = (r_ctl == CS_IDLE) && (!r_out_valid || o_result.ready);
    assign accept       = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    // result fields come straight from held state
    assign o_result.valid         = r_out_valid;
    assign o_result.phase         = r_phase;
    assign o_result.pump_on       = (r_phase == PH_FILL);
    assign o_result.valve_open    = (r_phase == PH_DRAIN);
    assign o_result.sample_taken  = r_taken;
    assign o_result.average_ready = r_avg_rdy;
    assign o_result.avg_ph        = r_mean_ph;
    assign o_result.avg_tds       = r_mean_tds;
    assign o_result.avg_temp      = r_mean_temp;

    // timer step, sample count bound and warm-up rule
    always_comb begin
        elapsed_inc = (r_elapsed != ELAPSED_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        total       = ({2'b00, r_samples_total} < MAX_LIM) ? r_samples_total
                                                            : MAX_LIM[CNT_W-1:0];
        keep        = (r_index >= r_warmup_drop) || (total <= r_warmup_drop);
    end

    // rounded dividend for the average being worked on
    always_comb begin
        half_k   = r_kept >> 1;
        temp_neg = r_temp_sum[TEMP_SUM_W-1];
        temp_mag = temp_neg ? -r_temp_sum : r_temp_sum;
        case (r_sel)
            DV_PH:   dividend = DIV_W'(r_ph_sum) + DIV_W'(half_k);
            DV_TDS:  dividend = r_tds_sum + DIV_W'(half_k);
            DV_TEMP: dividend = DIV_W'(temp_mag) + DIV_W'(half_k);
            default: dividend = '0;
        endcase
        div_start = (r_ctl == CS_DIV) && !div_stat.busy;
    end

    tsts_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_kept),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    // phase sequencing and average control
    always_comb begin
        n_phase     = r_phase;
        n_elapsed   = r_elapsed;
        n_index     = r_index;
        n_kept      = r_kept;
        n_ph_sum    = r_ph_sum;
        n_tds_sum   = r_tds_sum;
        n_temp_sum  = r_temp_sum;
        n_mean_ph   = r_mean_ph;
        n_mean_tds  = r_mean_tds;
        n_mean_temp = r_mean_temp;
        n_ctl       = r_ctl;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && !o_result.ready;
        n_taken     = r_taken;
        n_avg_rdy   = r_avg_rdy;

        case (r_ctl)
            CS_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_taken     = 1'b0;
                    n_avg_rdy   = 1'b0;
                    if (i_item.opcode == OP_START) begin
                        if (r_phase == PH_IDLE) begin
                            n_elapsed = '0;
                            n_phase   = PH_FILL;
                        end
                    end else begin
                        n_elapsed = elapsed_inc;
                        case (r_phase)
                            PH_FILL: begin
                                if (elapsed_inc >= r_fill_time) begin
                                    n_phase = PH_SETTLE;
                                end
                            end
                            PH_SETTLE: begin
                                if (elapsed_inc >= r_settle_time) begin
                                    n_index    = '0;
                                    n_kept     = '0;
                                    n_ph_sum   = '0;
                                    n_tds_sum  = '0;
                                    n_temp_sum = '0;
                                    n_elapsed  = '0;
                                    n_phase    = PH_READ;
                                end
                            end
                            PH_READ: begin
                                if (r_index < total) begin
                                    if (elapsed_inc >= TIME_W'(r_sample_period)) begin
                                        n_taken = 1'b1;
                                        if (keep) begin
                                            n_ph_sum   = r_ph_sum + PH_SUM_W'(i_item.ph_value);
                                            n_tds_sum  = r_tds_sum
                                                       + TDS_SUM_W'(i_item.tds_value);
                                            n_temp_sum = r_temp_sum
                                                       + TEMP_SUM_W'(i_item.temp_value);
                                            n_kept     = r_kept + 1'b1;
                                        end
                                        n_elapsed = '0;
                                        n_index   = r_index + 1'b1;
                                    end
                                end else begin
                                    // sums stay until the averages are done
                                    n_elapsed = '0;
                                    n_phase   = PH_DRAIN;
                                    if (r_kept != '0) begin
                                        n_out_valid = 1'b0;
                                        n_ctl       = CS_DIV;
                                        n_sel       = DV_PH;
                                    end
                                end
                            end
                            PH_DRAIN: begin
                                if (elapsed_inc >= r_drain_time) begin
                                    n_phase = PH_IDLE;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            CS_DIV: begin
                if (div_stat.done) begin
                    case (r_sel)
                        DV_PH: begin
                            n_mean_ph = quotient[PH_W-1:0];
                            n_sel     = DV_TDS;
                        end
                        DV_TDS: begin
                            n_mean_tds = quotient[TDS_W-1:0];
                            n_sel      = DV_TEMP;
                        end
                        default: begin
                            n_mean_temp = temp_neg ? -quotient[TEMP_W-1:0]
                                                   : quotient[TEMP_W-1:0];
                            n_ctl       = CS_IDLE;
                            n_out_valid = 1'b1;
                            n_avg_rdy   = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_ctl = CS_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_elapsed   <= '0;
            r_index     <= '0;
            r_kept      <= '0;
            r_ph_sum    <= '0;
            r_tds_sum   <= '0;
            r_temp_sum  <= '0;
            r_mean_ph   <= '0;
            r_mean_tds  <= '0;
            r_mean_temp <= '0;
            r_ctl       <= CS_IDLE;
            r_sel       <= DV_PH;
            r_out_valid <= 1'b0;
            r_taken     <= 1'b0;
            r_avg_rdy   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_elapsed   <= n_elapsed;
            r_index     <= n_index;
            r_kept      <= n_kept;
            r_ph_sum    <= n_ph_sum;
            r_tds_sum   <= n_tds_sum;
            r_temp_sum  <= n_temp_sum;
            r_mean_ph   <= n_mean_ph;
            r_mean_tds  <= n_mean_tds;
            r_mean_temp <= n_mean_temp;
            r_ctl       <= n_ctl;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
            r_taken     <= n_taken;
            r_avg_rdy   <= n_avg_rdy;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_time     <= FILL_TIME_RST;
            r_settle_time   <= SETTLE_TIME_RST;
            r_drain_time    <= DRAIN_TIME_RST;
            r_samples_total <= SAMPLES_TOTAL_RST;
            r_sample_period <= SAMPLE_PERIOD_RST;
            r_warmup_drop   <= WARMUP_DROP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FILL_TIME:     r_fill_time     <= i_cfg.wdata;
                CFG_SETTLE_TIME:   r_settle_time   <= i_cfg.wdata;
                CFG_DRAIN_TIME:    r_drain_time    <= i_cfg.wdata;
                CFG_SAMPLES_TOTAL: r_samples_total <= i_cfg.wdata[CNT_W-1:0];
                CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg.wdata[PERIOD_W-1:0];
                CFG_WARMUP_DROP:   r_warmup_drop   <= i_cfg.wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- test/timed_sampling_tank_sequencer_unit_tb.sv -----
// testbench of the sample tank sequencer: directed phase runs, random runs, status checks
`timescale 1ns / 1ps

module timed_sampling_tank_sequencer_unit_tb;
    import tsts_pkg::*;

    localparam int TANK_MAX_SAMPLES = 255;
    localparam int IDLE_LIMIT       = 1000;
    localparam int SETTLE_CYCLES    = 8;

    // index codes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // kinds of sensor readings
    localparam int READ_ANY  = 0;
    localparam int READ_EDGE = 1;
    localparam int READ_TINY = 2;
    localparam int READ_PEAK = 3;

    typedef struct packed {
        t_phase                    phase;
        logic                      pump_on;
        logic                      valve_open;
        logic                      sample_taken;
        logic                      average_ready;
        logic [PH_W-1:0]           avg_ph;
        logic [TDS_W-1:0]          avg_tds;
        logic signed [TEMP_W-1:0]  avg_temp;
    } t_tank_status;

    logic i_clk;
    logic i_rst_n;

    tsts_item_if   item_bus ();
    tsts_result_if result_bus ();
    tsts_cfg_if    cfg_bus ();

    timed_sampling_tank_sequencer_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // shadow copy of the registers
    logic [TIME_W-1:0]   fill_ms;
    logic [TIME_W-1:0]   settle_ms;
    logic [TIME_W-1:0]   drain_ms;
    logic [CNT_W-1:0]    total_cfg;
    logic [PERIOD_W-1:0] period_ms;
    logic [CNT_W-1:0]    warmup_cfg;

    // shadow copy of the sequencer state
    t_phase                   tank_phase;
    logic [TIME_W-1:0]        tank_elapsed;
    logic [CNT_W-1:0]         tank_index;
    logic [CNT_W-1:0]         tank_kept;
    logic [PH_SUM_W-1:0]      ph_acc;
    logic [TDS_SUM_W-1:0]     tds_acc;
    logic signed [TEMP_SUM_W-1:0] temp_acc;
    logic [PH_W-1:0]          ph_mean;
    logic [TDS_W-1:0]         tds_mean;
    logic signed [TEMP_W-1:0] temp_mean;

    t_tank_status status_queue[$];
    int unsigned  mismatches;
    int unsigned  requests_sent;
    int unsigned  result_hold;
    int unsigned  idle_cycles;
    bit           steady_flow;

    // next state and status of the tank for one request
    function automatic t_tank_status step_tank(input logic op, input logic [PH_W-1:0] ph,
                                               input logic [TDS_W-1:0] tds,
                                               input logic signed [TEMP_W-1:0] temp);
        t_tank_status st;
        logic         taken;
        logic         fresh;
        logic [CNT_W-1:0] total;
        longint       kept_l;
        longint       mag;
        longint       quot;
        taken = 1'b0;
        fresh = 1'b0;
        total = (total_cfg < TANK_MAX_SAMPLES) ? total_cfg : CNT_W'(TANK_MAX_SAMPLES);
        if (op == OP_START) begin
            if (tank_phase == PH_IDLE) begin
                tank_elapsed = '0;
                tank_phase   = PH_FILL;
            end
        end else begin
            if (tank_elapsed != ELAPSED_MAX) tank_elapsed = tank_elapsed + 1'b1;
            case (tank_phase)
                PH_FILL: begin
                    if (tank_elapsed >= fill_ms) tank_phase = PH_SETTLE;
                end
                PH_SETTLE: begin
                    if (tank_elapsed >= settle_ms) begin
                        tank_index   = '0;
                        tank_kept    = '0;
                        ph_acc       = '0;
                        tds_acc      = '0;
                        temp_acc     = '0;
                        tank_elapsed = '0;
                        tank_phase   = PH_READ;
                    end
                end
                PH_READ: begin
                    if (tank_index < total) begin
                        if (tank_elapsed >= period_ms) begin
                            taken = 1'b1;
                            // warm-up captures are dropped unless the run is that short
                            if (tank_index >= warmup_cfg || total <= warmup_cfg) begin
                                ph_acc    = ph_acc + ph;
                                tds_acc   = tds_acc + tds;
                                temp_acc  = temp_acc + temp;
                                tank_kept = tank_kept + 1'b1;
                            end
                            tank_elapsed = '0;
                            tank_index   = tank_index + 1'b1;
                        end
                    end else begin
                        // means rounded to nearest, ties away from zero
                        if (tank_kept != 0) begin
                            kept_l    = tank_kept;
                            ph_mean   = PH_W'((longint'(ph_acc) + kept_l / 2) / kept_l);
                            tds_mean  = TDS_W'((longint'(tds_acc) + kept_l / 2) / kept_l);
                            mag       = (temp_acc < 0) ? -longint'(temp_acc)
                                                       : longint'(temp_acc);
                            quot      = (mag + kept_l / 2) / kept_l;
                            temp_mean = TEMP_W'((temp_acc < 0) ? -quot : quot);
                            fresh     = 1'b1;
                        end
                        ph_acc       = '0;
                        tds_acc      = '0;
                        temp_acc     = '0;
                        tank_kept    = '0;
                        tank_elapsed = '0;
                        tank_phase   = PH_DRAIN;
                    end
                end
                PH_DRAIN: begin
                    if (tank_elapsed >= drain_ms) tank_phase = PH_IDLE;
                end
                default: ;
            endcase
        end
        st.phase         = tank_phase;
        st.pump_on       = (tank_phase == PH_FILL);
        st.valve_open    = (tank_phase == PH_DRAIN);
        st.sample_taken  = taken;
        st.average_ready = fresh;
        st.avg_ph        = ph_mean;
        st.avg_tds       = tds_mean;
        st.avg_temp      = temp_mean;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // one request, with a random gap before it unless the flow is steady
    task automatic send_request(input logic op, input logic [PH_W-1:0] ph,
                                input logic [TDS_W-1:0] tds,
                                input logic signed [TEMP_W-1:0] temp);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.opcode     <= op;
        item_bus.ph_value   <= ph;
        item_bus.tds_value  <= tds;
        item_bus.temp_value <= temp;
        status_queue.insert(status_queue.size(), step_tank(op, ph, tds, temp));
        requests_sent++;
        do @(posedge i_clk); while (!item_bus.ready);
    endtask

    task automatic draw_reading(input int mode, output logic [PH_W-1:0] ph,
                                output logic [TDS_W-1:0] tds,
                                output logic signed [TEMP_W-1:0] temp);
        int t;
        case (mode)
            READ_PEAK: begin
                ph   = '1;
                tds  = '1;
                temp = {1'b1, {(TEMP_W-1){1'b0}}};
            end
            READ_EDGE: begin
                case ($urandom_range(0, 2))
                    0: ph = '0;
                    1: ph = PH_W'(14000);
                    default: ph = '1;
                endcase
                tds = $urandom_range(0, 1) ? '1 : '0;
                case ($urandom_range(0, 4))
                    0: t = -5500;
                    1: t = 12500;
                    2: t = -16384;
                    3: t = 16383;
                    default: t = 0;
                endcase
                temp = TEMP_W'(t);
            end
            READ_TINY: begin
                ph   = PH_W'($urandom_range(0, 3));
                tds  = TDS_W'($urandom_range(0, 3));
                t    = int'($urandom_range(0, 6)) - 3;
                temp = TEMP_W'(t);
            end
            default: begin
                ph   = $urandom_range(0, 1) ? PH_W'($urandom_range(0, 14000)) : PH_W'($urandom);
                tds  = TDS_W'($urandom);
                t    = int'($urandom_range(0, 18000)) - 5500;
                temp = $urandom_range(0, 1) ? TEMP_W'(t) : TEMP_W'($urandom);
            end
        endcase
    endtask

    task automatic send_reading(input logic op, input int mode);
        logic [PH_W-1:0]          ph;
        logic [TDS_W-1:0]         tds;
        logic signed [TEMP_W-1:0] temp;
        draw_reading(mode, ph, tds, temp);
        send_request(op, ph, tds, temp);
    endtask

    // wait until every expected status has come and the block has gone quiet
    task automatic wait_settled();
        @(negedge i_clk);
        item_bus.valid <= 1'b0;
        while (status_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.wdata <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_FILL_TIME:     fill_ms    = data;
            CFG_SETTLE_TIME:   settle_ms  = data;
            CFG_DRAIN_TIME:    drain_ms   = data;
            CFG_SAMPLES_TOTAL: total_cfg  = data[CNT_W-1:0];
            CFG_SAMPLE_PERIOD: period_ms  = data[PERIOD_W-1:0];
            CFG_WARMUP_DROP:   warmup_cfg = data[CNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // narrow registers get random bits above their width, which must be ignored
    task automatic set_timing(input int fill, input int settle, input int drain,
                              input int total, input int period, input int warmup);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_register(CFG_FILL_TIME, CFG_DATA_W'(fill));
        write_register(CFG_SETTLE_TIME, CFG_DATA_W'(settle));
        write_register(CFG_DRAIN_TIME, CFG_DATA_W'(drain));
        write_register(CFG_SAMPLES_TOTAL, {junk[CFG_DATA_W-1:CNT_W], CNT_W'(total)});
        write_register(CFG_SAMPLE_PERIOD, {junk[CFG_DATA_W-1:PERIOD_W], PERIOD_W'(period)});
        write_register(CFG_WARMUP_DROP, {junk[CFG_DATA_W-1:CNT_W], CNT_W'(warmup)});
    endtask

    // start request, then ticks until the tank is idle again
    task automatic run_cycle(input int mode, input bit noisy);
        int guard;
        guard = 0;
        send_reading(OP_START, mode);
        while (tank_phase != PH_IDLE && guard < 200000) begin
            // a start while busy must be ignored
            if (noisy && $urandom_range(0, 9) == 0) send_reading(OP_START, mode);
            else send_reading(OP_TICK, mode);
            guard++;
        end
    endtask

    task automatic test_idle_after_reset();
        send_reading(OP_TICK, READ_ANY);
        send_reading(OP_TICK, READ_EDGE);
        wait_settled();
    endtask

    task automatic test_spare_index();
        write_register(CFG_SPARE_A, CFG_DATA_W'($urandom));
        write_register(CFG_SPARE_B, CFG_DATA_W'($urandom));
    endtask

    // zero timers and zero samples: read ends at once, means keep old values
    task automatic test_zero_timers();
        set_timing(0, 0, 0, 0, 0, 0);
        run_cycle(READ_EDGE, 1'b0);
        wait_settled();
    endtask

    // two captures whose means fall exactly halfway
    task automatic test_rounding_ties();
        set_timing(0, 0, 0, 2, 0, 0);
        send_request(OP_START, '0, '0, '0);
        send_request(OP_TICK, '0, '0, '0);
        send_request(OP_TICK, '0, '0, '0);
        send_request(OP_TICK, PH_W'(1), TDS_W'(1), -TEMP_W'(1));
        send_request(OP_TICK, PH_W'(2), TDS_W'(2), -TEMP_W'(2));
        send_request(OP_TICK, '0, '0, '0);
        send_request(OP_TICK, '0, '0, '0);
        wait_settled();
    endtask

    // warm-up drop, then a run no longer than the warm-up so all are kept
    task automatic test_warmup();
        set_timing(1, 3, 1, 4, 1, 2);
        run_cycle(READ_EDGE, 1'b1);
        wait_settled();
        set_timing(0, 0, 0, 3, 0, 3);
        run_cycle(READ_EDGE, 1'b0);
        wait_settled();
    endtask

    // largest sample count with peak readings fills the sums to the top
    task automatic test_full_read();
        steady_flow = 1'b1;
        set_timing(0, 0, 0, 255, 0, 255);
        run_cycle(READ_PEAK, 1'b0);
        wait_settled();
        steady_flow = 1'b0;
    endtask

    task automatic test_random_cycles();
        int unsigned target;
        int          mode;
        target = requests_sent + 1500;
        while (requests_sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 7) == 0)
                    set_timing($urandom_range(0, 3), $urandom_range(0, 6), $urandom_range(0, 3),
                               $urandom_range(20, 40), $urandom_range(0, 1),
                               $urandom_range(0, 40));
                else
                    set_timing($urandom_range(0, 6), $urandom_range(0, 15), $urandom_range(0, 6),
                               $urandom_range(0, 12), $urandom_range(0, 4),
                               $urandom_range(0, 14));
            end
            steady_flow = ($urandom_range(0, 3) == 0);
            mode = $urandom_range(0, 5);
            if (mode > READ_PEAK) mode = READ_ANY;
            // stray ticks while idle
            repeat ($urandom_range(0, 2)) send_reading(OP_TICK, mode);
            run_cycle(mode, $urandom_range(0, 1));
            wait_settled();
        end
        steady_flow = 1'b0;
    endtask

    // largest timers: the tank stays in fill for the rest of the run
    task automatic test_long_timers();
        set_timing(ELAPSED_MAX, ELAPSED_MAX, ELAPSED_MAX, 255, 65535, 255);
        send_reading(OP_START, READ_ANY);
        repeat (150) send_reading(OP_TICK, READ_ANY);
        send_reading(OP_START, READ_ANY);
        wait_settled();
    endtask

    // result ready with random stalls
    always @(negedge i_clk) begin
        if (result_hold > 0) begin
            result_bus.ready <= 1'b0;
            result_hold = result_hold - 1;
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    // status check and watchdog
    always @(posedge i_clk) begin
        t_tank_status want;
        if (item_bus.valid && item_bus.ready || cfg_bus.valid && cfg_bus.ready ||
            result_bus.valid && result_bus.ready)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (result_bus.valid && result_bus.ready) begin
            result_hold = steady_flow ? 0 : $urandom_range(0, 5);
            if (status_queue.size() == 0) begin
                report_mismatch("unexpected status", 1, 0);
            end else begin
                want = status_queue.pop_front();
                if (result_bus.phase !== want.phase)
                    report_mismatch("phase", result_bus.phase, want.phase);
                if (result_bus.pump_on !== want.pump_on)
                    report_mismatch("pump_on", result_bus.pump_on, want.pump_on);
                if (result_bus.valve_open !== want.valve_open)
                    report_mismatch("valve_open", result_bus.valve_open, want.valve_open);
                if (result_bus.sample_taken !== want.sample_taken)
                    report_mismatch("sample_taken", result_bus.sample_taken, want.sample_taken);
                if (result_bus.average_ready !== want.average_ready)
                    report_mismatch("average_ready", result_bus.average_ready,
                                    want.average_ready);
                if (result_bus.avg_ph !== want.avg_ph)
                    report_mismatch("avg_ph", result_bus.avg_ph, want.avg_ph);
                if (result_bus.avg_tds !== want.avg_tds)
                    report_mismatch("avg_tds", result_bus.avg_tds, want.avg_tds);
                if (result_bus.avg_temp !== want.avg_temp)
                    report_mismatch("avg_temp", $signed(result_bus.avg_temp),
                                    $signed(want.avg_temp));
            end
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no request or status moved for %0d cycles", $time, IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        item_bus.valid      = 1'b0;
        item_bus.opcode     = OP_TICK;
        item_bus.ph_value   = '0;
        item_bus.tds_value  = '0;
        item_bus.temp_value = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_FILL_TIME;
        cfg_bus.wdata       = '0;
        result_bus.ready    = 1'b0;
        result_hold         = 0;
        idle_cycles         = 0;
        mismatches          = 0;
        requests_sent       = 0;
        steady_flow         = 1'b0;
        fill_ms             = FILL_TIME_RST;
        settle_ms           = SETTLE_TIME_RST;
        drain_ms            = DRAIN_TIME_RST;
        total_cfg           = SAMPLES_TOTAL_RST;
        period_ms           = SAMPLE_PERIOD_RST;
        warmup_cfg          = WARMUP_DROP_RST;
        tank_phase          = PH_IDLE;
        tank_elapsed        = '0;
        tank_index          = '0;
        tank_kept           = '0;
        ph_acc              = '0;
        tds_acc             = '0;
        temp_acc            = '0;
        ph_mean             = '0;
        tds_mean            = '0;
        temp_mean           = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_spare_index();
        test_zero_timers();
        test_rounding_ties();
        test_warmup();
        test_full_read();
        test_random_cycles();
        test_long_timers();

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tsts_pkg.sv
rtl/tsts_item_if.sv
rtl/tsts_result_if.sv
rtl/tsts_cfg_if.sv
rtl/tsts_divider.sv
rtl/timed_sampling_tank_sequencer_unit.sv
test/timed_sampling_tank_sequencer_unit_tb.sv
